[rtl/tesc_pkg.sv]
`default_nettype none

package tesc_pkg;

    // request kinds
    localparam logic [2:0] REQ_ACCESS = 3'd0;
    localparam logic [2:0] REQ_FILL   = 3'd1;
    localparam logic [2:0] REQ_INVAL  = 3'd2;
    localparam logic [2:0] REQ_FLUSH  = 3'd3;
    localparam logic [2:0] REQ_CLEAR  = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic load_req;     // latch the input item
        logic ptr_zero;
        logic ptr_hand;     // scan pointer starts at the clock hand
        logic ptr_inc;      // advance scan pointer modulo entry count
        logic access;       // apply access, emit result
        logic fill_free;    // fill lowest invalid slot, emit result
        logic fill_victim;  // evict slot at pointer, fill it, emit result
        logic inv_step;     // invalidate entry at pointer on page match
        logic inv_emit;     // emit invalidate result
        logic flush_emit;   // emit entry at pointer, then invalidate it
        logic emit_null;    // emit all-zero result with last
        logic clear_all;
        logic clear_use;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] req_type;
        logic       out_free;
        logic       any_invalid;
        logic       any_valid;
        logic       cur_valid;
        logic       cur_class0;  // use 0, dirty 0 at pointer
        logic       cur_class1;  // use 0, dirty 1 at pointer
        logic       ptr_last;
        logic       more_valid;  // a valid entry above the pointer
    } status_t;

endpackage

`default_nettype wire

[rtl/tesc_dp.sv]
`default_nettype none

module tesc_dp
    import tesc_pkg::*;
#(
    parameter int TLB_ENTRIES = 4,
    parameter int PAGE_BITS   = 16,
    parameter int SLOT_W      = 2
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire cmd_t                 cmd,
    output status_t                   status,
    input  wire logic [2:0]           req_type,
    input  wire logic [SLOT_W-1:0]    entry_index,
    input  wire logic                 write_access,
    input  wire logic [PAGE_BITS-1:0] page_number,
    input  wire logic                 page_dirty,
    input  wire logic                 m_tready,
    output logic                      m_tvalid,
    output logic [SLOT_W-1:0]         slot,
    output logic                      victim_valid,
    output logic [PAGE_BITS-1:0]      victim_page,
    output logic                      victim_dirty,
    output logic                      last
);

    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(TLB_ENTRIES - 1);

    // latched request
    logic [2:0]           req_type_reg, req_type_next;
    logic [SLOT_W-1:0]    idx_reg, idx_next;
    logic                 wr_reg, wr_next;
    logic [PAGE_BITS-1:0] pg_reg, pg_next;
    logic                 pdirty_reg, pdirty_next;

    // entry state
    logic [TLB_ENTRIES-1:0] valid_reg, valid_next;
    logic [TLB_ENTRIES-1:0] use_reg, use_next;
    logic [TLB_ENTRIES-1:0] dirty_reg, dirty_next;
    logic [PAGE_BITS-1:0]   page_reg [TLB_ENTRIES];
    logic [SLOT_W-1:0]      hand_reg, hand_next;

    logic [SLOT_W-1:0] ptr_reg, ptr_next;
    logic              found_reg, found_next;
    logic [SLOT_W-1:0] first_reg, first_next;

    // result register
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic                 vv_reg, vv_next;
    logic [PAGE_BITS-1:0] vp_reg, vp_next;
    logic                 vd_reg, vd_next;
    logic                 last_reg, last_next;

    logic [PAGE_BITS-1:0] cur_page;
    logic [SLOT_W-1:0]    free_idx;
    logic [SLOT_W-1:0]    fill_slot;
    logic                 more_valid;
    logic                 inv_hit;
    logic                 idx_ok;
    logic                 fill;
    logic                 emit;
    logic                 out_free;

    assign cur_page = page_reg[ptr_reg];
    assign inv_hit  = valid_reg[ptr_reg] && (cur_page == pg_reg);
    assign idx_ok   = {1'b0, idx_reg} < (SLOT_W + 1)'(TLB_ENTRIES);
    assign fill     = cmd.fill_free || cmd.fill_victim;
    assign fill_slot = cmd.fill_victim ? ptr_reg : free_idx;
    assign emit     = cmd.access || cmd.fill_free || cmd.fill_victim || cmd.inv_emit
                      || cmd.flush_emit || cmd.emit_null;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        free_idx = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_idx = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        more_valid = 1'b0;
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            if (valid_reg[i] && (SLOT_W'(i) > ptr_reg)) begin
                more_valid = 1'b1;
            end
        end
    end

    always_comb begin
        status.req_type    = req_type_reg;
        status.out_free    = out_free;
        status.any_invalid = !(&valid_reg);
        status.any_valid   = |valid_reg;
        status.cur_valid   = valid_reg[ptr_reg];
        status.cur_class0  = !use_reg[ptr_reg] && !dirty_reg[ptr_reg];
        status.cur_class1  = !use_reg[ptr_reg] && dirty_reg[ptr_reg];
        status.ptr_last    = (ptr_reg == LAST_IDX);
        status.more_valid  = more_valid;
    end

    always_comb begin
        req_type_next = req_type_reg;
        idx_next      = idx_reg;
        wr_next       = wr_reg;
        pg_next       = pg_reg;
        pdirty_next   = pdirty_reg;
        if (cmd.load_req) begin
            req_type_next = req_type;
            idx_next      = entry_index;
            wr_next       = write_access;
            pg_next       = page_number;
            pdirty_next   = page_dirty;
        end
    end

    always_comb begin
        ptr_next = ptr_reg;
        if (cmd.ptr_zero) begin
            ptr_next = '0;
        end else if (cmd.ptr_hand) begin
            ptr_next = hand_reg;
        end else if (cmd.ptr_inc) begin
            ptr_next = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + 1'b1;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        use_next   = use_reg;
        dirty_next = dirty_reg;
        hand_next  = hand_reg;
        found_next = found_reg;
        first_next = first_reg;
        if (cmd.load_req) begin
            found_next = 1'b0;
        end
        if (cmd.clear_all) begin
            valid_next = '0;
        end
        if (cmd.clear_use) begin
            use_next = '0;
        end
        if (cmd.access && idx_ok && valid_reg[idx_reg]) begin
            use_next[idx_reg] = 1'b1;
            if (wr_reg) begin
                dirty_next[idx_reg] = 1'b1;
            end
        end
        if (fill) begin
            valid_next[fill_slot] = 1'b1;
            use_next[fill_slot]   = 1'b0;
            dirty_next[fill_slot] = pdirty_reg;
        end
        if (cmd.fill_victim) begin
            hand_next = ptr_reg;
        end
        if (cmd.inv_step && inv_hit) begin
            valid_next[ptr_reg] = 1'b0;
            if (!found_reg) begin
                found_next = 1'b1;
                first_next = ptr_reg;
            end
        end
        if (cmd.flush_emit) begin
            valid_next[ptr_reg] = 1'b0;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        slot_next     = slot_reg;
        vv_next       = vv_reg;
        vp_next       = vp_reg;
        vd_next       = vd_reg;
        last_next     = last_reg;
        if (emit) begin
            m_tvalid_next = 1'b1;
            slot_next     = '0;
            vv_next       = 1'b0;
            vp_next       = '0;
            vd_next       = 1'b0;
            last_next     = 1'b1;
            if (cmd.access) begin
                slot_next = idx_reg;
            end else if (cmd.fill_free) begin
                slot_next = free_idx;
            end else if (cmd.fill_victim || cmd.flush_emit) begin
                slot_next = ptr_reg;
                vv_next   = 1'b1;
                vp_next   = cur_page;
                vd_next   = dirty_reg[ptr_reg];
                last_next = cmd.fill_victim || !more_valid;
            end else if (cmd.inv_emit) begin
                if (found_reg) begin
                    slot_next = first_reg;
                end else if (inv_hit) begin
                    slot_next = ptr_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            use_reg      <= '0;
            dirty_reg    <= '0;
            hand_reg     <= '0;
            ptr_reg      <= '0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            valid_reg    <= valid_next;
            use_reg      <= use_next;
            dirty_reg    <= dirty_next;
            hand_reg     <= hand_next;
            ptr_reg      <= ptr_next;
            found_reg    <= found_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_type_reg <= req_type_next;
        idx_reg      <= idx_next;
        wr_reg       <= wr_next;
        pg_reg       <= pg_next;
        pdirty_reg   <= pdirty_next;
        first_reg    <= first_next;
        slot_reg     <= slot_next;
        vv_reg       <= vv_next;
        vp_reg       <= vp_next;
        vd_reg       <= vd_next;
        last_reg     <= last_next;
        if (fill) begin
            page_reg[fill_slot] <= pg_reg;
        end
    end

    assign m_tvalid     = m_tvalid_reg;
    assign slot         = slot_reg;
    assign victim_valid = vv_reg;
    assign victim_page  = vp_reg;
    assign victim_dirty = vd_reg;
    assign last         = last_reg;

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> out_free)
        else $error("result written while output register busy");

    a_victim_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fill_victim |-> (&valid_reg))
        else $error("eviction with a free slot available");

    a_fill_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        fill |=> valid_reg[slot_reg] && (hand_reg == $past(hand_next)))
        else $error("filled slot not valid after fill");

endmodule

`default_nettype wire

[rtl/tesc_ctrl.sv]
`default_nettype none

module tesc_ctrl
    import tesc_pkg::*;
#(
    parameter int TLB_ENTRIES = 4,
    parameter int SLOT_W      = 2
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire status_t status,
    output cmd_t         cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_VIC   = 3'd2;
    localparam logic [2:0] ST_INV   = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;

    localparam logic [SLOT_W-1:0] LAST_N = SLOT_W'(TLB_ENTRIES - 1);

    logic [2:0]        state_reg, state_next;
    logic [SLOT_W-1:0] n_reg, n_next;     // steps in the current lap
    logic              cls_reg, cls_next; // 0: clean candidates, 1: dirty ones
    logic              rnd_reg, rnd_next; // second round after use bits cleared
    logic              vic_hit;

    assign vic_hit = cls_reg ? status.cur_class1 : status.cur_class0;

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        cls_next   = cls_reg;
        rnd_next   = rnd_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_req = 1'b1;
                    cmd.ptr_zero = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (status.req_type)
                    REQ_ACCESS: begin
                        if (status.out_free) begin
                            cmd.access = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    REQ_FILL: begin
                        if (status.any_invalid) begin
                            if (status.out_free) begin
                                cmd.fill_free = 1'b1;
                                state_next    = ST_IDLE;
                            end
                        end else begin
                            cmd.ptr_hand = 1'b1;
                            n_next       = '0;
                            cls_next     = 1'b0;
                            rnd_next     = 1'b0;
                            state_next   = ST_VIC;
                        end
                    end
                    REQ_INVAL: begin
                        state_next = ST_INV;
                    end
                    REQ_FLUSH: begin
                        if (status.any_valid) begin
                            state_next = ST_FLUSH;
                        end else if (status.out_free) begin
                            cmd.emit_null = 1'b1;
                            state_next    = ST_IDLE;
                        end
                    end
                    REQ_CLEAR: begin
                        if (status.out_free) begin
                            cmd.emit_null = 1'b1;
                            cmd.clear_all = 1'b1;
                            state_next    = ST_IDLE;
                        end
                    end
                    default: begin
                        if (status.out_free) begin
                            cmd.emit_null = 1'b1;
                            state_next    = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_VIC: begin
                if (vic_hit) begin
                    if (status.out_free) begin
                        cmd.fill_victim = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end else begin
                    // a full lap brings the pointer back to the hand
                    cmd.ptr_inc = 1'b1;
                    if (n_reg == LAST_N) begin
                        n_next = '0;
                        if (!cls_reg) begin
                            cls_next = 1'b1;
                        end else begin
                            cls_next      = 1'b0;
                            cmd.clear_use = 1'b1;
                            rnd_next      = 1'b1;
                        end
                    end else begin
                        n_next = n_reg + 1'b1;
                    end
                end
            end
            ST_INV: begin
                if (!status.ptr_last) begin
                    cmd.inv_step = 1'b1;
                    cmd.ptr_inc  = 1'b1;
                end else if (status.out_free) begin
                    cmd.inv_step = 1'b1;
                    cmd.inv_emit = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (!status.cur_valid) begin
                    cmd.ptr_inc = 1'b1;
                end else if (status.out_free) begin
                    cmd.flush_emit = 1'b1;
                    if (status.more_valid) begin
                        cmd.ptr_inc = 1'b1;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
            cls_reg   <= 1'b0;
            rnd_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            n_reg     <= n_next;
            cls_reg   <= cls_next;
            rnd_reg   <= rnd_next;
        end
    end

    a_one_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({cmd.access, cmd.fill_free, cmd.fill_victim, cmd.inv_emit,
                    cmd.flush_emit, cmd.emit_null}) <= 1)
        else $error("more than one result written in a cycle");

    // after use bits are cleared every entry is a candidate of one class
    a_victim_found: assert property (@(posedge aclk) disable iff (!aresetn)
        !((state_reg == ST_VIC) && rnd_reg && cls_reg && (n_reg == LAST_N)
          && !status.cur_class1))
        else $error("victim scan exhausted without a victim");

endmodule

`default_nettype wire

[rtl/tlb_enhanced_second_chance_top.sv]
`default_nettype none

// Channel  Dir  tuser           tdata (low bit up)                              tlast
// s_       in   req_type[2:0]   entry_index, write_access, page_number, page_dirty  -
// m_       out  -               slot, victim_valid, victim_page, victim_dirty       last
//
// A fill into a full TLB walks the entries one per cycle from the clock hand:
// up to two laps, a use-bit clear, then at most one more lap and one step.
// Reset clears valid, use and dirty bits and the hand at once; no clearing pass.
// A result waits in the output register while m_tready is low; the next item
// is taken once the current request has written its last result there.

module tlb_enhanced_second_chance_top
    import tesc_pkg::*;
#(
    parameter int TLB_ENTRIES = 4,
    parameter int PAGE_BITS   = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // req_type
    input  wire logic [2:0]          s_tuser,
    // entry_index, write_access, page_number, page_dirty
    input  wire logic [((($clog2(TLB_ENTRIES) + PAGE_BITS + 2) + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // slot, victim_valid, victim_page, victim_dirty
    output logic [((($clog2(TLB_ENTRIES) + PAGE_BITS + 2) + 7) / 8) * 8 - 1:0] m_tdata,
    output logic                     m_tlast
);

    localparam int SLOT_W = $clog2(TLB_ENTRIES);
    localparam int FLD_W  = SLOT_W + PAGE_BITS + 2;
    localparam int DATA_W = ((FLD_W + 7) / 8) * 8;

    cmd_t    cmd;
    status_t status;

    logic [SLOT_W-1:0]    slot;
    logic                 victim_valid;
    logic [PAGE_BITS-1:0] victim_page;
    logic                 victim_dirty;

    tesc_ctrl #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .SLOT_W      (SLOT_W)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tesc_dp #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .PAGE_BITS   (PAGE_BITS),
        .SLOT_W      (SLOT_W)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .req_type     (s_tuser),
        .entry_index  (s_tdata[SLOT_W-1:0]),
        .write_access (s_tdata[SLOT_W]),
        .page_number  (s_tdata[SLOT_W+PAGE_BITS:SLOT_W+1]),
        .page_dirty   (s_tdata[SLOT_W+PAGE_BITS+1]),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .slot         (slot),
        .victim_valid (victim_valid),
        .victim_page  (victim_page),
        .victim_dirty (victim_dirty),
        .last         (m_tlast)
    );

    assign m_tdata = DATA_W'({victim_dirty, victim_page, victim_valid, slot});

endmodule

`default_nettype wire

[bench/tb_tlb_enhanced_second_chance_top.sv]
`timescale 1ns / 1ps

module tb_tlb_enhanced_second_chance_top;
    import tesc_pkg::*;

    localparam int TLB_ENTRIES  = 4;
    localparam int PAGE_BITS    = 16;
    localparam int TDATA_W      = 24;
    localparam int RANDOM_ITEMS = 260;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_CYCLES = 4 * TLB_ENTRIES + 8;

    // request codes the block does not decode; they should come back as a null result
    localparam logic [2:0] REQ_RSVD5 = 3'd5;
    localparam logic [2:0] REQ_RSVD6 = 3'd6;
    localparam logic [2:0] REQ_RSVD7 = 3'd7;

    typedef struct packed {
        bit [1:0]  slot;
        bit        victim_valid;
        bit [15:0] victim_page;
        bit        victim_dirty;
        bit        last;
    } tlb_result_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_CHOKE} rx_mode_e;

    // Shadow copy of the TLB replacement state plus the results it still owes.
    class tlb_shadow;
        bit [3:0]    valid;
        bit [3:0]    used;
        bit [3:0]    dirty;
        bit [15:0]   page [TLB_ENTRIES];
        bit [1:0]    hand;
        tlb_result_t owed [$];
        int          evictions;
        int          results_seen;

        function new();
            valid = '0;
            used  = '0;
            dirty = '0;
            hand  = '0;
            foreach (page[i]) page[i] = '0;
            evictions = 0;
            results_seen = 0;
        endfunction

        function void note_request(bit [2:0] kind, bit [1:0] idx, bit wr,
                                   bit [15:0] pg, bit pd);
            tlb_result_t r;
            bit [1:0]    h;
            bit [1:0]    pick;
            bit          found;
            int          n;
            int          emitted;

            r = '0;
            r.last = 1'b1;
            case (kind)
                REQ_ACCESS: begin
                    if (valid[idx]) begin
                        used[idx] = 1'b1;
                        if (wr) dirty[idx] = 1'b1;
                    end
                    r.slot = idx;
                    owed.push_back(r);
                end
                REQ_FILL: begin
                    found = 1'b0;
                    pick = '0;
                    for (n = 0; n < TLB_ENTRIES; n++) begin
                        if (!found && !valid[n]) begin
                            pick = n[1:0];
                            found = 1'b1;
                        end
                    end
                    if (!found) begin
                        // two passes: clean unused, then dirty unused, then drop use bits
                        h = hand;
                        for (int lap = 0; lap < 2 && !found; lap++) begin
                            for (int cls = 0; cls < 2 && !found; cls++) begin
                                for (n = 0; n < TLB_ENTRIES && !found; n++) begin
                                    if (!used[h] && dirty[h] == cls[0]) begin
                                        pick = h;
                                        found = 1'b1;
                                    end else begin
                                        h = h + 1'b1;
                                    end
                                end
                            end
                            if (!found) begin
                                for (n = 0; n < TLB_ENTRIES; n++) begin
                                    used[h] = 1'b0;
                                    h = h + 1'b1;
                                end
                            end
                        end
                        if (!found) pick = h;
                        hand = pick;
                        r.victim_valid = 1'b1;
                        r.victim_page  = page[pick];
                        r.victim_dirty = dirty[pick];
                        evictions++;
                    end
                    valid[pick] = 1'b1;
                    used[pick]  = 1'b0;
                    dirty[pick] = pd;
                    page[pick]  = pg;
                    r.slot = pick;
                    owed.push_back(r);
                end
                REQ_INVAL: begin
                    found = 1'b0;
                    for (n = 0; n < TLB_ENTRIES; n++) begin
                        if (valid[n] && page[n] == pg) begin
                            valid[n] = 1'b0;
                            if (!found) r.slot = n[1:0];
                            found = 1'b1;
                        end
                    end
                    owed.push_back(r);
                end
                REQ_FLUSH: begin
                    emitted = 0;
                    for (n = 0; n < TLB_ENTRIES; n++) begin
                        if (valid[n]) begin
                            r.slot         = n[1:0];
                            r.victim_valid = 1'b1;
                            r.victim_page  = page[n];
                            r.victim_dirty = dirty[n];
                            r.last         = 1'b0;
                            owed.push_back(r);
                            valid[n] = 1'b0;
                            emitted++;
                        end
                    end
                    if (emitted == 0) begin
                        r = '0;
                        r.last = 1'b1;
                        owed.push_back(r);
                    end else begin
                        owed[$].last = 1'b1;
                    end
                end
                REQ_CLEAR: begin
                    valid = '0;
                    owed.push_back(r);
                end
                default: owed.push_back(r);
            endcase
        endfunction

        // Empty string when the result matches the oldest owed one.
        function string check_result(tlb_result_t got);
            tlb_result_t want;
            string       diff;

            results_seen++;
            if (owed.size() == 0)
                return $sformatf("unexpected result slot=%0d vv=%0b page=%h dirty=%0b last=%0b",
                                 got.slot, got.victim_valid, got.victim_page,
                                 got.victim_dirty, got.last);
            want = owed.pop_front();
            diff = "";
            if (got.slot != want.slot)
                diff = {diff, $sformatf(" slot %0d/%0d", got.slot, want.slot)};
            if (got.victim_valid != want.victim_valid)
                diff = {diff, $sformatf(" victim_valid %0b/%0b",
                                        got.victim_valid, want.victim_valid)};
            if (got.victim_page != want.victim_page)
                diff = {diff, $sformatf(" victim_page %h/%h",
                                        got.victim_page, want.victim_page)};
            if (got.victim_dirty != want.victim_dirty)
                diff = {diff, $sformatf(" victim_dirty %0b/%0b",
                                        got.victim_dirty, want.victim_dirty)};
            if (got.last != want.last)
                diff = {diff, $sformatf(" last %0b/%0b", got.last, want.last)};
            if (diff != "") diff = {"result field mismatch (got/exp):", diff};
            return diff;
        endfunction
    endclass

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [2:0]         s_tuser  = '0;   // req_type
    logic [TDATA_W-1:0] s_tdata  = '0;   // entry_index, write_access, page_number, page_dirty
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;         // slot, victim_valid, victim_page, victim_dirty
    logic               m_tlast;

    tlb_shadow shadow = new();
    int        mismatches = 0;
    int        cycle_count = 0;
    int        kind_count [8];
    rx_mode_e  rx_mode = RX_OPEN;
    int        rx_timer = 0;

    tlb_enhanced_second_chance_top #(
        .TLB_ENTRIES(TLB_ENTRIES),
        .PAGE_BITS  (PAGE_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser (s_tuser),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always #5 aclk = ~aclk;

    task automatic report_mismatch(string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        mismatches++;
    endtask

    task automatic send_request(bit [2:0] kind, bit [1:0] idx, bit wr, bit [15:0] pg, bit pd);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0, pd, pg, wr, idx};
        do @(posedge aclk); while (!s_tready);
        shadow.note_request(kind, idx, wr, pg, pd);
        kind_count[kind]++;
    endtask

    task automatic pause_sender(int cycles);
        if (cycles > 0) begin
            s_tvalid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (shadow.owed.size() != 0) @(posedge aclk);
    endtask

    // result side: check every accepted item, and vary tready in phases
    always @(posedge aclk) begin : result_side
        string verdict;
        if (aresetn && m_tvalid && m_tready) begin
            verdict = shadow.check_result({m_tdata[1:0], m_tdata[2], m_tdata[18:3],
                                           m_tdata[19], m_tlast});
            if (verdict != "") report_mismatch(verdict);
        end
        if (rx_timer == 0) begin
            rx_mode  <= rx_mode_e'($urandom_range(0, 2));
            rx_timer <= $urandom_range(20, 80);
        end else begin
            rx_timer <= rx_timer - 1;
        end
        case (rx_mode)
            RX_OPEN:  m_tready <= 1'b1;
            RX_COIN:  m_tready <= $urandom_range(0, 1);
            default:  m_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, shadow.owed.size());
            $display("tb_tlb_enhanced_second_chance_top failed");
            $finish;
        end
    end

    initial begin
        int        n;
        int        b;
        int        burst;
        int        roll;
        int        s;
        bit [2:0]  kind;
        bit [1:0]  idx;
        bit        wr;
        bit        pd;
        bit [15:0] pg;

        foreach (kind_count[i]) kind_count[i] = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table corner cases
        send_request(REQ_FLUSH,  2'd0, 1'b0, 16'h0000, 1'b0);
        send_request(REQ_ACCESS, 2'd0, 1'b1, 16'h0000, 1'b0);
        send_request(REQ_INVAL,  2'd3, 1'b0, 16'h0000, 1'b0);
        // fill all slots, including a duplicate page
        send_request(REQ_FILL,   2'd0, 1'b0, 16'h0000, 1'b0);
        send_request(REQ_FILL,   2'd3, 1'b1, 16'hFFFF, 1'b1);
        send_request(REQ_FILL,   2'd0, 1'b0, 16'h1234, 1'b0);
        send_request(REQ_FILL,   2'd0, 1'b0, 16'h1234, 1'b1);
        send_request(REQ_ACCESS, 2'd0, 1'b0, 16'hFFFF, 1'b1);
        send_request(REQ_ACCESS, 2'd1, 1'b1, 16'h0000, 1'b0);
        send_request(REQ_ACCESS, 2'd3, 1'b0, 16'h0000, 1'b0);
        // evict a clean unused slot, then make everything used and dirty
        send_request(REQ_FILL,   2'd0, 1'b0, 16'hA5A5, 1'b0);
        send_request(REQ_ACCESS, 2'd0, 1'b1, 16'h0000, 1'b0);
        send_request(REQ_ACCESS, 2'd1, 1'b1, 16'h0000, 1'b0);
        send_request(REQ_ACCESS, 2'd2, 1'b1, 16'h0000, 1'b0);
        send_request(REQ_ACCESS, 2'd3, 1'b1, 16'h0000, 1'b0);
        // two full laps without a candidate: use bits cleared, then a dirty victim
        send_request(REQ_FILL,   2'd0, 1'b0, 16'h5A5A, 1'b1);
        send_request(REQ_INVAL,  2'd0, 1'b0, 16'h1234, 1'b0);
        send_request(REQ_RSVD5,  2'd3, 1'b1, 16'hFFFF, 1'b1);
        send_request(REQ_RSVD6,  2'd0, 1'b0, 16'h0000, 1'b0);
        send_request(REQ_RSVD7,  2'd1, 1'b1, 16'h8001, 1'b1);
        send_request(REQ_FLUSH,  2'd0, 1'b0, 16'h0000, 1'b0);
        send_request(REQ_FILL,   2'd0, 1'b0, 16'h0F0F, 1'b1);
        send_request(REQ_FILL,   2'd0, 1'b0, 16'hF0F0, 1'b0);
        send_request(REQ_CLEAR,  2'd0, 1'b0, 16'h0000, 1'b0);
        send_request(REQ_ACCESS, 2'd1, 1'b1, 16'h0000, 1'b0);
        send_request(REQ_FILL,   2'd2, 1'b1, 16'h7777, 1'b0);
        drain_results();

        n = 0;
        while (n < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 12);
            for (b = 0; b < burst && n < RANDOM_ITEMS; b++) begin
                roll = $urandom_range(0, 99);
                idx  = $urandom_range(0, 3);
                wr   = $urandom_range(0, 1);
                pd   = $urandom_range(0, 1);
                // a small page pool makes duplicates and invalidate hits likely
                if ($urandom_range(0, 3) == 0) pg = $urandom_range(0, 3);
                else pg = $urandom();
                if (roll < 40) begin
                    kind = REQ_ACCESS;
                end else if (roll < 75) begin
                    kind = REQ_FILL;
                end else if (roll < 86) begin
                    kind = REQ_INVAL;
                    if (roll < 82 && shadow.valid != '0) begin
                        do s = $urandom_range(0, 3); while (!shadow.valid[s]);
                        pg = shadow.page[s];
                    end
                end else if (roll < 92) begin
                    kind = REQ_FLUSH;
                end else if (roll < 96) begin
                    kind = REQ_CLEAR;
                end else begin
                    kind = $urandom_range(REQ_RSVD5, REQ_RSVD7);
                end
                send_request(kind, idx, wr, pg, pd);
                n++;
            end
            if ($urandom_range(0, 15) == 0) drain_results();
            else if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 6));
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d access, %0d fill, %0d invalidate, %0d flush, %0d clear, %0d reserved",
                 kind_count[REQ_ACCESS], kind_count[REQ_FILL], kind_count[REQ_INVAL],
                 kind_count[REQ_FLUSH], kind_count[REQ_CLEAR],
                 kind_count[REQ_RSVD5] + kind_count[REQ_RSVD6] + kind_count[REQ_RSVD7]);
        $display("Checked %0d results, %0d evicting fills, %0d mismatches",
                 shadow.results_seen, shadow.evictions, mismatches);
        if (mismatches == 0) begin
            $display("tb_tlb_enhanced_second_chance_top passed");
        end else begin
            $display("tb_tlb_enhanced_second_chance_top failed");
        end
        $finish;
    end

endmodule
